// ===== src/pcbtm_pkg.sv =====
// Shared types and constants for the per-core busy time monitor.
// No dependencies; compiled first.
package pcbtm_pkg;

  localparam int CORE_W    = 4;
  localparam int TIME_IN_W = 32;
  localparam int UTIL_W    = 14;

  localparam logic [UTIL_W-1:0] UTIL_FULL = 14'd10000;

  // Event kinds on the input channel
  typedef enum logic [1:0] {
    KIND_ACTIVATE = 2'd0,
    KIND_IDLE     = 2'd1,
    KIND_OTHER    = 2'd2,
    KIND_REPORT   = 2'd3
  } kind_t;

endpackage

// ===== src/pcbtm_in_if.sv =====
// Trace event channel: valid/ready handshake with event payload.
// Depends on pcbtm_pkg.
interface pcbtm_in_if;
  import pcbtm_pkg::*;

  logic                  valid;
  logic                  ready;
  kind_t                 kind;
  logic [CORE_W-1:0]     core_id;
  logic [TIME_IN_W-1:0]  event_time;

  modport source (output valid, output kind, output core_id, output event_time,
                  input ready);
  modport sink   (input valid, input kind, input core_id, input event_time,
                  output ready);
endinterface

// ===== src/pcbtm_out_if.sv =====
// Utilization result channel: valid/ready handshake with one result per beat.
// Depends on pcbtm_pkg.
interface pcbtm_out_if;
  import pcbtm_pkg::*;

  logic               valid;
  logic               ready;
  logic [CORE_W-1:0]  out_core;
  logic [UTIL_W-1:0]  utilization;
  logic               has_data;
  logic               zero_span;
  logic               last_of_report;

  modport source (output valid, output out_core, output utilization, output has_data,
                  output zero_span, output last_of_report, input ready);
  modport sink   (input valid, input out_core, input utilization, input has_data,
                  input zero_span, input last_of_report, output ready);
endinterface

// ===== src/pcbtm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcbtm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/per_core_busy_time_monitor.sv =====
// Per-core busy time monitor: event table updates and utilization report.
// Depends on pcbtm_pkg, pcbtm_in_if, pcbtm_out_if and pcbtm_ram.
//
//  channel  | dir | payload                                           | beats per item
//  ---------+-----+---------------------------------------------------+------------------
//  events   | in  | kind, core_id, event_time                         | 1
//  results  | out | out_core, utilization, has_data, zero_span, last  | NUM_CORES per report
//
//  Steps: activate and other events finish in the idle state; a zone-closing idle
//  event goes through start read, length subtract and total add; a report walks each
//  core through RAM read, compare, 4 multiply steps, 14 divide steps and output load,
//  or just read, compare and output load if the result saturates or the span is zero.
//  Zone and report arithmetic uses one shared adder/subtractor, which sets the pace.
//  Reset (rst, synchronous) clears open zones, completion flags and the latest
//  time; stored totals read as zero until a core closes its first zone.
//  A stalled results channel holds the sequencer in its output step; the block
//  accepts the next event as soon as the last result of a report is loaded.
module per_core_busy_time_monitor #(
  parameter int NUM_CORES = 16,
  parameter int TIME_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  pcbtm_in_if.sink          events,
  pcbtm_out_if.source       results
);
  import pcbtm_pkg::*;

  localparam int CW     = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int TB     = TIME_BITS;
  // busy * 10000 stays below 2^(TB+14) because busy < span on this path
  localparam int UW     = TB + UTIL_W;
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(3);            // 10000 = 5^4 * 16
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(UTIL_W - 1);
  localparam logic [CW-1:0]     LAST_CORE = CW'(NUM_CORES - 1);

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_CLOSE_LEN = 8'b0000_0010,
    ST_CLOSE_ADD = 8'b0000_0100,
    ST_RPT_RD    = 8'b0000_1000,
    ST_RPT_CMP   = 8'b0001_0000,
    ST_MUL       = 8'b0010_0000,
    ST_DIV       = 8'b0100_0000,
    ST_OUT       = 8'b1000_0000
  } state_t;

  state_t state;

  // Per-core flags in flip-flops; closed_any also marks a valid busy total
  logic [NUM_CORES-1:0] zone_open;
  logic [NUM_CORES-1:0] closed_any;
  logic [TB-1:0]        latest_time;

  // Working registers
  logic [CW-1:0]     addr;
  logic [TB-1:0]     t_reg;
  logic [TB-1:0]     len;
  logic [UW-1:0]     acc;
  logic [TB-1:0]     rem;
  logic [UTIL_W-1:0] quo;
  logic [STEP_W-1:0] step;
  logic [UTIL_W-1:0] util;

  // Result register
  logic              o_valid;
  logic [CORE_W-1:0] o_core;
  logic [UTIL_W-1:0] o_util;
  logic              o_has;
  logic              o_zs;
  logic              o_last;

  // Input decode
  logic          accept;
  logic [CW-1:0] in_addr;
  logic          in_range;
  logic [TB-1:0] t_in;

  assign accept   = events.valid && events.ready;
  assign in_addr  = CW'(events.core_id);
  assign in_range = 32'(events.core_id) < NUM_CORES;
  assign t_in     = TB'(events.event_time);
  assign events.ready = (state == ST_IDLE);

  // RAMs: zone start times and busy totals
  logic          start_we;
  logic          busy_we;
  logic [CW-1:0] raddr;
  logic [TB-1:0] start_rd;
  logic [TB-1:0] busy_rd;
  logic [TB-1:0] busy_cur;
  logic [TB-1:0] busy_wdata;

  assign raddr    = (state == ST_IDLE) ? in_addr : addr;
  assign start_we = accept && (events.kind == KIND_ACTIVATE) && in_range &&
                    !zone_open[in_addr];
  assign busy_we  = (state == ST_CLOSE_ADD);
  assign busy_cur = closed_any[addr] ? busy_rd : '0;

  pcbtm_ram #(.WIDTH(TB), .DEPTH(NUM_CORES)) u_start_ram (
    .clk   (clk),
    .we    (start_we),
    .waddr (in_addr),
    .wdata (t_in),
    .raddr (raddr),
    .rdata (start_rd)
  );

  pcbtm_ram #(.WIDTH(TB), .DEPTH(NUM_CORES)) u_busy_ram (
    .clk   (clk),
    .we    (busy_we),
    .waddr (addr),
    .wdata (busy_wdata),
    .raddr (raddr),
    .rdata (busy_rd)
  );

  // Shared adder/subtractor; carry out on subtract means a >= b
  logic [UW-1:0] alu_a;
  logic [UW-1:0] alu_b;
  logic          alu_sub;
  logic [UW:0]   alu_res;
  logic          alu_carry;
  logic [TB:0]   rem2;

  assign rem2 = {rem, quo[UTIL_W-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      ST_CLOSE_LEN: begin
        alu_a   = UW'(t_reg);
        alu_b   = UW'(start_rd);
        alu_sub = 1'b1;
      end
      ST_CLOSE_ADD: begin
        alu_a = UW'(busy_cur);
        alu_b = UW'(len);
      end
      ST_RPT_CMP: begin
        alu_a   = UW'(busy_cur);
        alu_b   = UW'(latest_time);
        alu_sub = 1'b1;
      end
      ST_MUL: begin
        alu_a = acc << 2;
        alu_b = acc;
      end
      ST_DIV: begin
        alu_a   = UW'(rem2);
        alu_b   = UW'(latest_time);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_res   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} +
                     {{UW{1'b0}}, alu_sub};
  assign alu_carry = alu_res[UW];

  // Saturate the busy total at the all-ones time value
  assign busy_wdata = alu_res[TB] ? '1 : alu_res[TB-1:0];

  logic out_free;
  assign out_free = !o_valid || results.ready;

  // Sequencer and table state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      zone_open   <= '0;
      closed_any  <= '0;
      latest_time <= '0;
      addr        <= '0;
      step        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (events.kind == KIND_REPORT) begin
              addr  <= '0;
              state <= ST_RPT_RD;
            end else begin
              if (t_in > latest_time) begin
                latest_time <= t_in;
              end
              if (start_we) begin
                zone_open[in_addr] <= 1'b1;
              end
              if ((events.kind == KIND_IDLE) && in_range && zone_open[in_addr]) begin
                addr  <= in_addr;
                state <= ST_CLOSE_LEN;
              end
            end
          end
        end
        ST_CLOSE_LEN: begin
          state <= ST_CLOSE_ADD;
        end
        ST_CLOSE_ADD: begin
          zone_open[addr]  <= 1'b0;
          closed_any[addr] <= 1'b1;
          state            <= ST_IDLE;
        end
        ST_RPT_RD: begin
          state <= ST_RPT_CMP;
        end
        ST_RPT_CMP: begin
          if ((latest_time == '0) || alu_carry) begin
            state <= ST_OUT;
          end else begin
            step  <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          step <= step + 1'b1;
          if (step == MUL_LAST) begin
            step  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          step <= step + 1'b1;
          if (step == DIV_LAST) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            if (addr == LAST_CORE) begin
              state <= ST_IDLE;
            end else begin
              addr  <= addr + 1'b1;
              state <= ST_RPT_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      t_reg <= t_in;
    end
    case (state)
      ST_CLOSE_LEN: begin
        // a zone that ends before its start adds nothing
        len <= alu_carry ? alu_res[TB-1:0] : '0;
      end
      ST_RPT_CMP: begin
        acc <= UW'(busy_cur);
        if (latest_time == '0) begin
          util <= '0;
        end else if (alu_carry) begin
          util <= UTIL_FULL;
        end
      end
      ST_MUL: begin
        acc <= alu_res[UW-1:0];
        if (step == MUL_LAST) begin
          // product = final multiply result * 16; seed remainder with its top bits
          rem <= alu_res[TB+9:10];
          quo <= {alu_res[9:0], 4'b0000};
        end
      end
      ST_DIV: begin
        rem <= alu_carry ? alu_res[TB-1:0] : rem2[TB-1:0];
        quo <= {quo[UTIL_W-2:0], alu_carry};
        if (step == DIV_LAST) begin
          util <= {quo[UTIL_W-2:0], alu_carry};
        end
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if ((state == ST_OUT) && out_free) begin
      o_valid <= 1'b1;
    end else if (results.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      o_core <= CORE_W'(addr);
      o_util <= util;
      o_has  <= closed_any[addr];
      o_zs   <= (latest_time == '0);
      o_last <= (addr == LAST_CORE);
    end
  end

  assign results.valid          = o_valid;
  assign results.out_core       = o_core;
  assign results.utilization    = o_util;
  assign results.has_data       = o_has;
  assign results.zero_span      = o_zs;
  assign results.last_of_report = o_last;

  // A report beat starts the per-core walk
  a_report_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && (events.kind == KIND_REPORT)) |=> (state == ST_RPT_RD))
    else $error("report accepted without starting the core walk");

  // Closing a zone clears the open flag and marks the core
  a_close_updates: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLOSE_ADD) |=> (!zone_open[$past(addr)] && closed_any[$past(addr)]))
    else $error("zone close did not update core flags");

  // The divider never produces more than full scale
  a_util_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> (util <= UTIL_FULL))
    else $error("utilization above full scale");

  // The latest time only moves forward
  a_latest_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (latest_time >= $past(latest_time)))
    else $error("latest time decreased");

endmodule
